### hdl/msm_pkg.sv
package msm_pkg;

   // Field and register widths
   localparam int SPIN_WIDTH_DEF = 16;
   localparam int GAUSS_W        = 16;
   localparam int SCALE_W        = 16;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_IDX_W      = 1;

   // Working format: vectors are built with 30 fraction bits
   localparam int WORK_FRAC = 30;
   localparam int PROD_W    = GAUSS_W + SCALE_W + 1;  // gauss * scale, signed
   localparam int VEC_W     = 39;                     // signed working vector
   localparam int MAGX_W    = VEC_W - 1;              // its magnitude
   localparam int MAG_W     = 30;                     // normalized magnitude
   localparam int POS_W     = 6;                      // leading-one position
   localparam int ROOT_W    = 31;                     // isqrt of the sum of squares
   localparam int REM_W     = 63;                     // square-root remainder

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MOVE_MODE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_SCALE = 1'd1;

   // Move codes
   typedef enum logic [1:0] {
      MODE_FLIP    = 2'd0,
      MODE_UNIFORM = 2'd1,
      MODE_CONE    = 2'd2,
      MODE_PICK    = 2'd3
   } mode_type;

   localparam mode_type MOVE_MODE_RST  = MODE_PICK;
   localparam logic [SCALE_W-1:0] STEP_SCALE_RST = 16'd4096;

   // Per-item control that rides alongside the normalizer
   typedef struct packed {
      logic       flip;
      logic       zero;
      logic [2:0] neg;
   } ctl_type;

endpackage

### hdl/msm_front.sv
module msm_front import msm_pkg::*; #(
   parameter int SPIN_WIDTH = SPIN_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [2:0][SPIN_WIDTH-1:0]        in_old,
   input  logic [2:0][GAUSS_W-1:0]           in_gauss,
   input  logic [SCALE_W-1:0]                in_pick,
   input  mode_type                          mode,
   input  logic [SCALE_W-1:0]                scale,
   output logic                              out_valid,
   output logic [2:0][MAG_W-1:0]             out_mag,
   output logic [2:0][SPIN_WIDTH-1:0]        out_flip,
   output ctl_type                           out_ctl
);

   localparam int FRAC   = SPIN_WIDTH - 2;
   localparam int OLD_SH = WORK_FRAC - FRAC;
   localparam logic [SPIN_WIDTH-1:0] SPIN_MIN = {1'b1, {(SPIN_WIDTH-1){1'b0}}};
   localparam logic [SPIN_WIDTH-1:0] SPIN_MAX = {1'b0, {(SPIN_WIDTH-1){1'b1}}};
   localparam logic [POS_W-1:0] TOP_POS = POS_W'(MAG_W - 1);

   logic [4:0] valid_ff;

   // Stage 1: move pick, products, negated spin
   mode_type                       mode1_ff, mode1_in;
   logic [2:0][SPIN_WIDTH-1:0]     old1_ff;
   logic [2:0][GAUSS_W-1:0]        g1_ff;
   logic [2:0][PROD_W-1:0]         prod1_ff, prod1_in;
   logic [2:0][SPIN_WIDTH-1:0]     flip1_ff, flip1_in;
   logic [SCALE_W+1:0]             three_u;

   always_comb begin
      three_u  = {2'b00, in_pick} + {1'b0, in_pick, 1'b0};
      mode1_in = (mode == MODE_PICK) ? mode_type'(three_u[SCALE_W+1:SCALE_W]) : mode;
      for (int i = 0; i < 3; i++) begin
         prod1_in[i] = $signed(in_gauss[i]) * $signed({1'b0, scale});
         flip1_in[i] = (in_old[i] == SPIN_MIN) ? SPIN_MAX : -in_old[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode1_ff <= mode1_in;
         old1_ff  <= in_old;
         g1_ff    <= in_gauss;
         prod1_ff <= prod1_in;
         flip1_ff <= flip1_in;
      end
   end

   // Stage 2: vector to normalize at 30 fraction bits (12 in uniform mode)
   logic [2:0][VEC_W-1:0]          v2_ff, v2_in;
   logic                           isflip2_ff;
   logic [2:0][SPIN_WIDTH-1:0]     flip2_ff;

   always_comb begin
      logic signed [VEC_W-1:0] oe;
      logic signed [VEC_W-1:0] pe;
      logic signed [VEC_W-1:0] ge;
      for (int i = 0; i < 3; i++) begin
         oe = VEC_W'($signed(old1_ff[i])) <<< OLD_SH;
         pe = VEC_W'($signed(prod1_ff[i])) <<< 6;
         ge = VEC_W'($signed(g1_ff[i]));
         v2_in[i] = (mode1_ff == MODE_UNIFORM) ? ge : oe + pe;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v2_ff      <= v2_in;
         isflip2_ff <= (mode1_ff == MODE_FLIP);
         flip2_ff   <= flip1_ff;
      end
   end

   // Stage 3: signs and magnitudes
   logic [2:0][MAGX_W-1:0]         mag3_ff, mag3_in;
   logic [2:0]                     neg3_ff;
   logic                           isflip3_ff;
   logic [2:0][SPIN_WIDTH-1:0]     flip3_ff;

   always_comb begin
      logic [VEC_W-1:0] a;
      for (int i = 0; i < 3; i++) begin
         a = v2_ff[i][VEC_W-1] ? -v2_ff[i] : v2_ff[i];
         mag3_in[i] = a[MAGX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag3_ff    <= mag3_in;
         neg3_ff    <= {v2_ff[2][VEC_W-1], v2_ff[1][VEC_W-1], v2_ff[0][VEC_W-1]};
         isflip3_ff <= isflip2_ff;
         flip3_ff   <= flip2_ff;
      end
   end

   // Stage 4: leading-one position of the largest magnitude
   logic [MAGX_W-1:0]              orv;
   logic [POS_W-1:0]               pos4_ff, pos4_in;
   logic                           zero4_ff;
   logic [2:0][MAGX_W-1:0]         mag4_ff;
   logic [2:0]                     neg4_ff;
   logic                           isflip4_ff;
   logic [2:0][SPIN_WIDTH-1:0]     flip4_ff;

   always_comb begin
      orv     = mag3_ff[0] | mag3_ff[1] | mag3_ff[2];
      pos4_in = '0;
      for (int b = 0; b < MAGX_W; b++) begin
         if (orv[b]) pos4_in = POS_W'(b);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos4_ff    <= pos4_in;
         zero4_ff   <= ~|orv;
         mag4_ff    <= mag3_ff;
         neg4_ff    <= neg3_ff;
         isflip4_ff <= isflip3_ff;
         flip4_ff   <= flip3_ff;
      end
   end

   // Stage 5: shift so the largest lies in [2^29, 2^30)
   logic [2:0][MAG_W-1:0]          mag5_ff, mag5_in;
   ctl_type                        ctl5_ff;
   logic [2:0][SPIN_WIDTH-1:0]     flip5_ff;

   always_comb begin
      logic [MAGX_W-1:0] s;
      for (int i = 0; i < 3; i++) begin
         if (pos4_ff >= TOP_POS) s = mag4_ff[i] >> (pos4_ff - TOP_POS);
         else                    s = mag4_ff[i] << (TOP_POS - pos4_ff);
         mag5_in[i] = s[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag5_ff      <= mag5_in;
         ctl5_ff.flip <= isflip4_ff;
         ctl5_ff.zero <= zero4_ff;
         ctl5_ff.neg  <= neg4_ff;
         flip5_ff     <= flip4_ff;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   assign out_valid = valid_ff[4];
   assign out_mag   = mag5_ff;
   assign out_flip  = flip5_ff;
   assign out_ctl   = ctl5_ff;

endmodule

### hdl/msm_sqrt.sv
module msm_sqrt import msm_pkg::*; #(
   parameter int PASS_W = 53
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [2:0][MAG_W-1:0]     in_mag,
   input  logic [PASS_W-1:0]         in_pass,
   output logic                      out_valid,
   output logic [2:0][MAG_W-1:0]     out_mag,
   output logic [PASS_W-1:0]         out_pass,
   output logic [ROOT_W-1:0]         out_root
);

   // Stage 0 squares, stage 1 sums, then one root bit per stage
   localparam int DEPTH = ROOT_W + 2;
   localparam int SQ_W  = 2 * MAG_W;

   logic [DEPTH-1:0]              valid_ff;
   logic [2:0][MAG_W-1:0]         mag_ff  [DEPTH];
   logic [PASS_W-1:0]             pass_ff [DEPTH];
   logic [2:0][SQ_W-1:0]          sq_ff, sq_in;
   logic [REM_W-1:0]              rem_ff  [1:DEPTH-1];
   logic [REM_W-1:0]              root_ff [1:DEPTH-1];

   always_comb begin
      for (int i = 0; i < 3; i++) sq_in[i] = in_mag[i] * in_mag[i];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff      <= sq_in;
         mag_ff[0]  <= in_mag;
         pass_ff[0] <= in_pass;
         rem_ff[1]  <= REM_W'(sq_ff[0]) + REM_W'(sq_ff[1]) + REM_W'(sq_ff[2]);
         root_ff[1] <= '0;
         for (int s = 1; s < DEPTH; s++) begin
            mag_ff[s]  <= mag_ff[s-1];
            pass_ff[s] <= pass_ff[s-1];
         end
      end
   end

   // Digit-by-digit square root steps
   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      localparam logic [REM_W-1:0] BIT_V = REM_W'(1) << (2 * (ROOT_W - 1 - k));
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] rem_in, root_in;

      always_comb begin
         trial = root_ff[k+1] + BIT_V;
         if (rem_ff[k+1] >= trial) begin
            rem_in  = rem_ff[k+1] - trial;
            root_in = (root_ff[k+1] >> 1) + BIT_V;
         end else begin
            rem_in  = rem_ff[k+1];
            root_in = root_ff[k+1] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+2]  <= rem_in;
            root_ff[k+2] <= root_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_mag   = mag_ff[DEPTH-1];
   assign out_pass  = pass_ff[DEPTH-1];
   assign out_root  = root_ff[DEPTH-1][ROOT_W-1:0];

endmodule

### hdl/msm_div.sv
module msm_div import msm_pkg::*; #(
   parameter int SPIN_WIDTH = SPIN_WIDTH_DEF,
   parameter int PASS_W     = 53
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [2:0][MAG_W-1:0]             in_mag,
   input  logic [ROOT_W-1:0]                 in_root,
   input  logic [PASS_W-1:0]                 in_pass,
   output logic                              out_valid,
   output logic [2:0][SPIN_WIDTH-2:0]        out_quot,
   output logic [PASS_W-1:0]                 out_pass
);

   // Quotient has FRAC+1 bits; one restoring step per stage, three lanes
   localparam int FRAC = SPIN_WIDTH - 2;
   localparam int Q_W  = FRAC + 1;
   localparam int DW   = MAG_W + FRAC + 2;

   logic [Q_W:0]                  valid_ff;
   logic [2:0][DW-1:0]            rem_ff  [Q_W+1];
   logic [2:0][Q_W-1:0]           q_ff    [Q_W+1];
   logic [ROOT_W-1:0]             root_ff [Q_W+1];
   logic [PASS_W-1:0]             pass_ff [Q_W+1];

   // Stage 0: rounded numerator
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= (DW'(in_mag[i]) << FRAC) + DW'(in_root >> 1);
         end
         q_ff[0]    <= '0;
         root_ff[0] <= in_root;
         pass_ff[0] <= in_pass;
      end
   end

   for (genvar s = 1; s <= Q_W; s++) begin : g_step
      localparam int SH = Q_W - s;
      logic [2:0][DW-1:0]  rem_in;
      logic [2:0][Q_W-1:0] q_in;

      always_comb begin
         logic [DW-1:0] d;
         d = DW'(root_ff[s-1]) << SH;
         for (int i = 0; i < 3; i++) begin
            if (rem_ff[s-1][i] >= d) begin
               rem_in[i] = rem_ff[s-1][i] - d;
               q_in[i]   = {q_ff[s-1][i][Q_W-2:0], 1'b1};
            end else begin
               rem_in[i] = rem_ff[s-1][i];
               q_in[i]   = {q_ff[s-1][i][Q_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            q_ff[s]    <= q_in;
            root_ff[s] <= root_ff[s-1];
            pass_ff[s] <= pass_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[Q_W-1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_quot  = q_ff[Q_W];
   assign out_pass  = pass_ff[Q_W];

endmodule

### hdl/monte_carlo_spin_move.sv
// Trial spin proposal for a Heisenberg Monte Carlo step.
// Input channel req_*: old spin (signed, SPIN_WIDTH-2 fraction bits), three
// Gaussian samples (Q3.12) and one uniform sample. Result channel rsp_*: the
// trial spin in the old spin's format plus a zero-length flag.
// csr_*: write-only registers, move_mode (index 0) and step_scale (index 1).
// Write them only while no item is in flight.
// The pipeline has 5 front-end stages that build and normalize the vector, 33
// stages that square, sum and take the integer square root one bit per stage,
// SPIN_WIDTH divider stages (a rounding stage, then one quotient bit per stage)
// and one output register.
// Throughput is one item per cycle. The whole pipeline advances together;
// when rsp_valid is high and rsp_ready is low every stage holds and
// req_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads move_mode = 3, step_scale = 1.0.
module monte_carlo_spin_move import msm_pkg::*; #(
   parameter int SPIN_WIDTH = SPIN_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SPIN_WIDTH-1:0]  req_spin_in_x,
   input  logic signed [SPIN_WIDTH-1:0]  req_spin_in_y,
   input  logic signed [SPIN_WIDTH-1:0]  req_spin_in_z,
   input  logic signed [GAUSS_W-1:0]     req_gauss_a,
   input  logic signed [GAUSS_W-1:0]     req_gauss_b,
   input  logic signed [GAUSS_W-1:0]     req_gauss_c,
   input  logic [SCALE_W-1:0]            req_pick_uniform,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SPIN_WIDTH-1:0]  rsp_new_x,
   output logic signed [SPIN_WIDTH-1:0]  rsp_new_y,
   output logic signed [SPIN_WIDTH-1:0]  rsp_new_z,
   output logic                          rsp_zero_length,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wr_data
);

   localparam int PASS_W = 3 * SPIN_WIDTH + $bits(ctl_type);

   logic en;

   // Configuration registers
   mode_type              mode_ff;
   logic [SCALE_W-1:0]    scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MOVE_MODE_RST;
         scale_ff <= STEP_SCALE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MOVE_MODE:  mode_ff  <= mode_type'(csr_wr_data[1:0]);
            REG_STEP_SCALE: scale_ff <= csr_wr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Whole pipeline moves when the output register is free or being taken
   logic rsp_valid_ff;
   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;

   // Front end: move pick, vector build, normalizing shift
   logic                          fr_valid;
   logic [2:0][MAG_W-1:0]         fr_mag;
   logic [2:0][SPIN_WIDTH-1:0]    fr_flip;
   ctl_type                       fr_ctl;

   msm_front #(.SPIN_WIDTH(SPIN_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_old    ({req_spin_in_z, req_spin_in_y, req_spin_in_x}),
      .in_gauss  ({req_gauss_c, req_gauss_b, req_gauss_a}),
      .in_pick   (req_pick_uniform),
      .mode      (mode_ff),
      .scale     (scale_ff),
      .out_valid (fr_valid),
      .out_mag   (fr_mag),
      .out_flip  (fr_flip),
      .out_ctl   (fr_ctl)
   );

   // Sum of squares and integer square root
   logic                      sq_valid;
   logic [2:0][MAG_W-1:0]     sq_mag;
   logic [PASS_W-1:0]         sq_pass;
   logic [ROOT_W-1:0]         sq_root;

   msm_sqrt #(.PASS_W(PASS_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_mag    (fr_mag),
      .in_pass   ({fr_flip, fr_ctl}),
      .out_valid (sq_valid),
      .out_mag   (sq_mag),
      .out_pass  (sq_pass),
      .out_root  (sq_root)
   );

   // Rounded division of each magnitude by the root
   logic                          dv_valid;
   logic [2:0][SPIN_WIDTH-2:0]    dv_quot;
   logic [PASS_W-1:0]             dv_pass;
   logic [2:0][SPIN_WIDTH-1:0]    dv_flip;
   ctl_type                       dv_ctl;

   msm_div #(.SPIN_WIDTH(SPIN_WIDTH), .PASS_W(PASS_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_mag    (sq_mag),
      .in_root   (sq_root),
      .in_pass   (sq_pass),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_pass  (dv_pass)
   );

   assign {dv_flip, dv_ctl} = dv_pass;

   // Output register: restore signs, pick flip or zero result
   logic [2:0][SPIN_WIDTH-1:0] res_ff, res_in;
   logic                       zero_ff;

   always_comb begin
      logic [SPIN_WIDTH-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = SPIN_WIDTH'(dv_quot[i]);
         if (dv_ctl.flip)      res_in[i] = dv_flip[i];
         else if (dv_ctl.zero) res_in[i] = '0;
         else if (dv_ctl.neg[i]) res_in[i] = -q;
         else                  res_in[i] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff  <= res_in;
         zero_ff <= dv_ctl.zero & ~dv_ctl.flip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_x       = res_ff[0];
   assign rsp_new_y       = res_ff[1];
   assign rsp_new_z       = res_ff[2];
   assign rsp_zero_length = zero_ff;

   // Checks
   a_zero_gives_zeros: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |->
         rsp_new_x == '0 && rsp_new_y == '0 && rsp_new_z == '0)
      else $error("zero-length result with nonzero components");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds_front: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(fr_valid) && $stable(fr_ctl))
      else $error("front end moved during a stall");

endmodule

### bench/monte_carlo_spin_move_tb.sv
`timescale 1ns / 100ps

module monte_carlo_spin_move_tb import msm_pkg::*;;

   localparam int SW        = SPIN_WIDTH_DEF;
   localparam int SFRAC     = SW - 2;
   localparam int DRAIN_CYC = 70;

   typedef struct {
      logic signed [SW-1:0]      sx, sy, sz;
      logic signed [GAUSS_W-1:0] ga, gb, gc;
      logic [SCALE_W-1:0]        pu;
   } move_req_type;

   typedef struct {
      logic signed [SW-1:0] x, y, z;
      logic                 zl;
   } trial_spin_type;

   typedef struct {
      mode_type           mode;
      logic [SCALE_W-1:0] scale;
      move_req_type       req;
      bit                 known;
      trial_spin_type     res;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SW-1:0]      req_spin_in_x = '0, req_spin_in_y = '0, req_spin_in_z = '0;
   logic signed [GAUSS_W-1:0] req_gauss_a = '0, req_gauss_b = '0, req_gauss_c = '0;
   logic [SCALE_W-1:0]        req_pick_uniform = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SW-1:0] rsp_new_x, rsp_new_y, rsp_new_z;
   logic rsp_zero_length;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // shadow of the block's registers
   mode_type           cur_mode  = MOVE_MODE_RST;
   logic [SCALE_W-1:0] cur_scale = STEP_SCALE_RST;

   trial_spin_type expected_spins[$];
   dir_row_type    dir_tab[$];
   int             err_cnt = 0;
   bit             quiet   = 1'b0;   // no idling on either side

   monte_carlo_spin_move #(.SPIN_WIDTH(SW)) DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic logic [SW-1:0] sat_spin(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (SW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[SW-1:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bv;
      res = 0;
      bv  = 64'd1 << 62;
      while (bv > n) bv = bv >> 2;
      while (bv != 0) begin
         if (n >= res + bv) begin
            n   = n - (res + bv);
            res = (res >> 1) + bv;
         end else begin
            res = res >> 1;
         end
         bv = bv >> 2;
      end
      return res;
   endfunction

   // scale vector onto the unit sphere
   function automatic trial_spin_type unit_vector(longint vx, longint vy, longint vz);
      longint v[3];
      longint unsigned mag[3], m, s, r, q;
      bit neg[3];
      logic [SW-1:0] o[3];
      trial_spin_type res;
      v[0] = vx; v[1] = vy; v[2] = vz;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? -v[i] : v[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         res.x = '0; res.y = '0; res.z = '0; res.zl = 1'b1;
         return res;
      end
      while (m >= (64'd1 << 30)) begin
         m = m >> 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (m < (64'd1 << 29)) begin
         m = m << 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      s = 0;
      for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
      r = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q    = ((mag[i] << SFRAC) + (r >> 1)) / r;
         o[i] = sat_spin(neg[i] ? -longint'(q) : longint'(q));
      end
      res.x = o[0]; res.y = o[1]; res.z = o[2]; res.zl = 1'b0;
      return res;
   endfunction

   function automatic trial_spin_type predict_move(move_req_type t);
      mode_type eff;
      trial_spin_type res;
      longint k;
      eff = cur_mode;
      if (eff == MODE_PICK) eff = mode_type'((longint'(t.pu) * 3) >> 16);
      k = longint'(cur_scale) * 64;
      case (eff)
         MODE_FLIP: begin
            res.x  = sat_spin(-longint'(t.sx));
            res.y  = sat_spin(-longint'(t.sy));
            res.z  = sat_spin(-longint'(t.sz));
            res.zl = 1'b0;
         end
         MODE_UNIFORM: res = unit_vector(t.ga, t.gb, t.gc);
         default: res = unit_vector(longint'(t.sx) * (64'sd1 <<< (WORK_FRAC - SFRAC)) + t.ga * k,
                                    longint'(t.sy) * (64'sd1 <<< (WORK_FRAC - SFRAC)) + t.gb * k,
                                    longint'(t.sz) * (64'sd1 <<< (WORK_FRAC - SFRAC)) + t.gc * k);
      endcase
      return res;
   endfunction

   // ---------------- driving ----------------
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == REG_MOVE_MODE) cur_mode = mode_type'(data[1:0]);
      else cur_scale = data;
   endtask

   // stop sending, then wait for every result to come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_spins.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   // upper data bits are junk for the mode register
   task automatic set_config(mode_type md, logic [SCALE_W-1:0] sc);
      wait_idle();
      csr_write(REG_MOVE_MODE, {16'($urandom) & 16'hFFFC} | 16'(md));
      csr_write(REG_STEP_SCALE, sc);
   endtask

   task automatic send_item(move_req_type t, bit known, trial_spin_type res);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_spin_in_x    <= t.sx;
      req_spin_in_y    <= t.sy;
      req_spin_in_z    <= t.sz;
      req_gauss_a      <= t.ga;
      req_gauss_b      <= t.gb;
      req_gauss_c      <= t.gc;
      req_pick_uniform <= t.pu;
      do @(posedge clock); while (!req_ready);
      expected_spins.push_back(known ? res : predict_move(t));
   endtask

   function automatic logic [15:0] rand_field(bit wide, int span);
      if (wide) return 16'($urandom);
      if ($urandom_range(0, 15) == 0) return '0;
      return 16'($urandom_range(0, 2 * span) - span);
   endfunction

   function automatic move_req_type rand_req();
      move_req_type t;
      bit wide;
      wide = $urandom_range(0, 3) == 0;
      t.sx = rand_field(wide, 16384);
      t.sy = rand_field(wide, 16384);
      t.sz = rand_field(wide, 16384);
      wide = $urandom_range(0, 3) == 0;
      t.ga = rand_field(wide, 12288);
      t.gb = rand_field(wide, 12288);
      t.gc = rand_field(wide, 12288);
      t.pu = 16'($urandom);
      return t;
   endfunction

   task automatic add_row(mode_type md, logic [15:0] sc,
                          logic [15:0] sx, sy, sz, ga, gb, gc, pu,
                          bit known, logic [15:0] ex, ey, ez, logic ezl);
      dir_row_type r;
      r.mode = md; r.scale = sc;
      r.req.sx = sx; r.req.sy = sy; r.req.sz = sz;
      r.req.ga = ga; r.req.gb = gb; r.req.gc = gc; r.req.pu = pu;
      r.known = known;
      r.res.x = ex; r.res.y = ey; r.res.z = ez; r.res.zl = ezl;
      dir_tab.push_back(r);
   endtask

   // result side stalls
   initial begin
      int stall;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 9);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // result checking
   always @(posedge clock) begin
      trial_spin_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_spins.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10) $display("unexpected item: %0d %0d %0d zl=%0b",
                                        rsp_new_x, rsp_new_y, rsp_new_z, rsp_zero_length);
         end else begin
            e = expected_spins.pop_front();
            if (rsp_new_x !== e.x || rsp_new_y !== e.y || rsp_new_z !== e.z ||
                rsp_zero_length !== e.zl) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("mismatch: exp %0d %0d %0d zl=%0b, got %0d %0d %0d zl=%0b",
                           e.x, e.y, e.z, e.zl,
                           rsp_new_x, rsp_new_y, rsp_new_z, rsp_zero_length);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      trial_spin_type none;
      mode_type pm[8];
      logic [15:0] ps[8];
      none = '{default: '0};

      // pick mode at reset defaults first, then each fixed move
      add_row(MODE_PICK, 4096, 100, -200, 300, 0, 0, 0, 0, 1, -100, 200, -300, 0);
      add_row(MODE_PICK, 4096, -32768, 0, 0, 5, 6, 7, 21845, 1, 32767, 0, 0, 0);
      add_row(MODE_PICK, 4096, 0, 0, 0, 0, -4096, 0, 21846, 1, 0, -16384, 0, 0);
      add_row(MODE_PICK, 4096, 1, 2, 3, 0, 0, 0, 43690, 1, 0, 0, 0, 1);
      add_row(MODE_PICK, 4096, 16384, 0, 0, 100, -100, 50, 43691, 0, 0, 0, 0, 0);
      add_row(MODE_PICK, 4096, 0, 16384, 0, -32768, 32767, 0, 65535, 0, 0, 0, 0, 0);
      add_row(MODE_FLIP, 4096, -32768, 32767, 0, 0, 0, 0, 0, 1, 32767, -32767, 0, 0);
      add_row(MODE_FLIP, 4096, 32767, -1, -32768, 1, 1, 1, 65535, 0, 0, 0, 0, 0);
      add_row(MODE_UNIFORM, 4096, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
      add_row(MODE_UNIFORM, 4096, 0, 0, 0, 4096, 0, 0, 0, 1, 16384, 0, 0, 0);
      add_row(MODE_UNIFORM, 4096, 0, 0, 0, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0);
      add_row(MODE_UNIFORM, 4096, 5, 5, 5, 32767, -32768, 1, 0, 0, 0, 0, 0, 0);
      add_row(MODE_UNIFORM, 4096, 0, 0, 0, 0, 0, -1, 0, 0, 0, 0, 0, 0);
      add_row(MODE_CONE, 4096, 16384, 0, 0, -4096, 0, 0, 0, 1, 0, 0, 0, 1);
      add_row(MODE_CONE, 4096, 0, 0, 16384, 1, -1, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_CONE, 0, 16384, 0, 0, 999, -999, 7, 0, 1, 16384, 0, 0, 0);
      add_row(MODE_CONE, 0, 0, 0, 0, 32767, 32767, 32767, 0, 1, 0, 0, 0, 1);
      add_row(MODE_CONE, 65535, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0);
      add_row(MODE_CONE, 65535, -32768, -32768, -32768, -32768, -32768, -32768, 0,
              0, 0, 0, 0, 0);
      add_row(MODE_CONE, 65535, 1, -1, 0, -1, 1, 0, 0, 0, 0, 0, 0, 0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].mode != cur_mode || dir_tab[i].scale != cur_scale)
            set_config(dir_tab[i].mode, dir_tab[i].scale);
         send_item(dir_tab[i].req, dir_tab[i].known, dir_tab[i].res);
      end

      // random phases over the settings, extremes included
      pm = '{MODE_FLIP, MODE_UNIFORM, MODE_CONE, MODE_CONE, MODE_CONE, MODE_CONE,
             MODE_PICK, MODE_PICK};
      ps = '{16'($urandom), 16'($urandom), 16'd0, 16'd65535, 16'd4096,
             16'($urandom), 16'($urandom), 16'd4096};
      for (int p = 0; p < 8; p++) begin
         @(negedge clock);
         req_valid <= 1'b0;
         set_config(pm[p], ps[p]);
         quiet = (p % 3 == 1);
         for (int n = 0; n < 190; n++) begin
            if (p == 4 && n == 95) begin
               @(negedge clock);
               req_valid <= 1'b0;
               while (expected_spins.size() != 0) @(posedge clock);
            end
            send_item(rand_req(), 1'b0, none);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;
      quiet = 1'b0;

      wait_idle();
      if (err_cnt == 0 && expected_spins.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### monte_carlo_spin_move.f
hdl/msm_pkg.sv
hdl/msm_front.sv
hdl/msm_sqrt.sv
hdl/msm_div.sv
hdl/monte_carlo_spin_move.sv
bench/monte_carlo_spin_move_tb.sv
